/* src/bbmg_pkg.sv */
// ----------------------------------------------------------------------------
// bbmg_pkg
// Shared widths, codes, types and the corner table of the brick box mesh
// generator.
// ----------------------------------------------------------------------------
package bbmg_pkg;

    // field widths
    localparam int DIM_W     = 11;               // volume sizes, edge, counts, coords
    localparam int CELL_W    = 11;               // cell position of an input word
    localparam int CRD_W     = CELL_W + 1;       // cell plus corner offset
    localparam int IDX_W     = 31;               // vertex index
    localparam int STRZ_W    = 2 * DIM_W - 1;    // (bx+1)*(by+1) fits 21 bits
    localparam int REG_IDX_W = 2;
    localparam int STEP_W    = $clog2(DIM_W);

    localparam int MAX_VOLUME_DIM    = 1024;
    localparam int INDICES_PER_BRICK = 36;
    localparam int K_W               = $clog2(INDICES_PER_BRICK);

    localparam logic [DIM_W-1:0] MAX_DIM      = DIM_W'(MAX_VOLUME_DIM);
    localparam logic [DIM_W-1:0] VOLUME_RESET = DIM_W'(1);
    localparam logic [DIM_W-1:0] EDGE_RESET   = DIM_W'(32);
    localparam logic [K_W-1:0]   K_LAST       = K_W'(INDICES_PER_BRICK - 1);

    // configuration register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_VOLUME_X,
        REG_VOLUME_Y,
        REG_VOLUME_Z,
        REG_BRICK_EDGE
    } reg_index_t;

    // input word actions
    localparam logic ACT_VERTEX = 1'b0;
    localparam logic ACT_BRICK  = 1'b1;

    // geometry unit states
    typedef enum logic [1:0] {
        GEO_IDLE,
        GEO_LOAD,
        GEO_DIV,
        GEO_MUL
    } geo_state_t;

    // grid geometry handed from the geometry unit to the mesh pipeline
    typedef struct packed {
        logic               busy;
        logic [DIM_W-1:0]   brick_len;
        logic [DIM_W-1:0]   dim_x;
        logic [DIM_W-1:0]   dim_y;
        logic [DIM_W-1:0]   dim_z;
        logic [DIM_W-1:0]   cnt_x;
        logic [DIM_W-1:0]   cnt_y;
        logic [DIM_W-1:0]   cnt_z;
        logic [DIM_W-1:0]   stride_y;
        logic [STRZ_W-1:0]  stride_z;
    } geom_t;

    // box corners of the 12 triangles: bit0 x at max, bit1 y at max, bit2 z at max
    localparam logic [2:0] CORNER_CODE [INDICES_PER_BRICK] = '{
        3'd5, 3'd1, 3'd3, 3'd5, 3'd3, 3'd7, 3'd7, 3'd3, 3'd2, 3'd7, 3'd2, 3'd6,
        3'd7, 3'd6, 3'd4, 3'd7, 3'd4, 3'd5, 3'd4, 3'd6, 3'd2, 3'd4, 3'd2, 3'd0,
        3'd4, 3'd0, 3'd1, 3'd4, 3'd1, 3'd5, 3'd0, 3'd2, 3'd3, 3'd0, 3'd3, 3'd1
    };

endpackage

/* src/bbmg_if.sv */
// ----------------------------------------------------------------------------
// bbmg_if
// Valid/ready channels of the brick box mesh generator: query words in,
// vertex words out.
// ----------------------------------------------------------------------------
interface bbmg_query_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [bbmg_pkg::CELL_W-1:0] cell_x;
    logic [bbmg_pkg::CELL_W-1:0] cell_y;
    logic [bbmg_pkg::CELL_W-1:0] cell_z;

    modport source (output valid, action, cell_x, cell_y, cell_z, input ready);
    modport sink   (input valid, action, cell_x, cell_y, cell_z, output ready);
endinterface

interface bbmg_vertex_if;
    logic                        valid;
    logic                        ready;
    logic [bbmg_pkg::IDX_W-1:0]  vertex_index;
    logic [bbmg_pkg::DIM_W-1:0]  coord_x;
    logic [bbmg_pkg::DIM_W-1:0]  coord_y;
    logic [bbmg_pkg::DIM_W-1:0]  coord_z;
    logic                        bad_cell;
    logic                        last;

    modport source (output valid, vertex_index, coord_x, coord_y, coord_z, bad_cell, last,
                    input ready);
    modport sink   (input valid, vertex_index, coord_x, coord_y, coord_z, bad_cell, last,
                    output ready);
endinterface

/* src/bbmg_geom.sv */
// ----------------------------------------------------------------------------
// bbmg_geom
// Configuration registers and grid geometry: brick counts per axis by three
// bit-serial dividers, then the row and slice strides of the vertex grid.
// ----------------------------------------------------------------------------
module bbmg_geom
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bbmg_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [bbmg_pkg::DIM_W-1:0]     cfg_data,
    output bbmg_pkg::geom_t                geo
);
    import bbmg_pkg::*;

    logic [DIM_W-1:0]   vol_x_reg;
    logic [DIM_W-1:0]   vol_y_reg;
    logic [DIM_W-1:0]   vol_z_reg;
    logic [DIM_W-1:0]   brick_reg;

    geo_state_t         state_reg;
    geo_state_t         state_next;
    logic [STEP_W-1:0]  step_reg;
    logic [DIM_W-1:0]   rem_reg [3];
    logic [DIM_W-1:0]   quo_reg [3];
    logic [DIM_W-1:0]   rem_next [3];
    logic [DIM_W-1:0]   quo_next [3];

    logic [DIM_W-1:0]   cnt_x_reg;
    logic [DIM_W-1:0]   cnt_y_reg;
    logic [DIM_W-1:0]   cnt_z_reg;
    logic [DIM_W-1:0]   stride_y_reg;
    logic [STRZ_W-1:0]  stride_z_reg;

    logic [DIM_W-1:0]   brick_len;
    logic [DIM_W-1:0]   dim_x;
    logic [DIM_W-1:0]   dim_y;
    logic [DIM_W-1:0]   dim_z;
    logic [DIM_W-1:0]   row_len;
    logic [DIM_W-1:0]   col_len;
    logic [2*DIM_W-1:0] slice_full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vol_x_reg <= VOLUME_RESET;
            vol_y_reg <= VOLUME_RESET;
            vol_z_reg <= VOLUME_RESET;
            brick_reg <= EDGE_RESET;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_VOLUME_X:   vol_x_reg <= cfg_data;
                REG_VOLUME_Y:   vol_y_reg <= cfg_data;
                REG_VOLUME_Z:   vol_z_reg <= cfg_data;
                REG_BRICK_EDGE: brick_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // zero edge acts as one, oversized volumes saturate
    assign brick_len = (brick_reg == '0) ? DIM_W'(1) : brick_reg;
    assign dim_x     = (vol_x_reg > MAX_DIM) ? MAX_DIM : vol_x_reg;
    assign dim_y     = (vol_y_reg > MAX_DIM) ? MAX_DIM : vol_y_reg;
    assign dim_z     = (vol_z_reg > MAX_DIM) ? MAX_DIM : vol_z_reg;

    // one restoring division step per axis
    always_comb
    begin
        logic [DIM_W:0] trial;
        logic [DIM_W:0] diff;
        logic           ge;
        for (int a = 0; a < 3; a++)
        begin
            trial       = {rem_reg[a], quo_reg[a][DIM_W-1]};
            diff        = trial - {1'b0, brick_len};
            ge          = (trial >= {1'b0, brick_len});
            rem_next[a] = ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
            quo_next[a] = {quo_reg[a][DIM_W-2:0], ge};
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= GEO_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            GEO_IDLE: state_next = GEO_IDLE;
            GEO_LOAD: state_next = GEO_DIV;
            GEO_DIV:
            begin
                if (step_reg == STEP_W'(DIM_W - 1))
                    state_next = GEO_MUL;
            end
            GEO_MUL:  state_next = GEO_IDLE;
            default:  state_next = GEO_IDLE;
        endcase
        if (cfg_we)
            state_next = GEO_LOAD;
    end

    // divider datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            GEO_LOAD:
            begin
                step_reg   <= '0;
                rem_reg[0] <= '0;
                rem_reg[1] <= '0;
                rem_reg[2] <= '0;
                quo_reg[0] <= dim_x;
                quo_reg[1] <= dim_y;
                quo_reg[2] <= dim_z;
            end
            GEO_DIV:
            begin
                step_reg <= step_reg + STEP_W'(1);
                for (int a = 0; a < 3; a++)
                begin
                    rem_reg[a] <= rem_next[a];
                    quo_reg[a] <= quo_next[a];
                end
            end
            default: ;
        endcase
    end

    // strides of the vertex grid
    assign row_len    = quo_reg[0] + DIM_W'(1);
    assign col_len    = quo_reg[1] + DIM_W'(1);
    assign slice_full = {{DIM_W{1'b0}}, row_len} * {{DIM_W{1'b0}}, col_len};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_x_reg    <= '0;
            cnt_y_reg    <= '0;
            cnt_z_reg    <= '0;
            stride_y_reg <= DIM_W'(1);
            stride_z_reg <= STRZ_W'(1);
        end
        else if (state_reg == GEO_MUL)
        begin
            cnt_x_reg    <= quo_reg[0];
            cnt_y_reg    <= quo_reg[1];
            cnt_z_reg    <= quo_reg[2];
            stride_y_reg <= row_len;
            stride_z_reg <= slice_full[STRZ_W-1:0];
        end
    end

    assign geo.busy      = (state_reg != GEO_IDLE) || cfg_we;
    assign geo.brick_len = brick_len;
    assign geo.dim_x     = dim_x;
    assign geo.dim_y     = dim_y;
    assign geo.dim_z     = dim_z;
    assign geo.cnt_x     = cnt_x_reg;
    assign geo.cnt_y     = cnt_y_reg;
    assign geo.cnt_z     = cnt_z_reg;
    assign geo.stride_y  = stride_y_reg;
    assign geo.stride_z  = stride_z_reg;

endmodule

/* src/brick_box_mesh_generator.sv */
// ----------------------------------------------------------------------------
// brick_box_mesh_generator
// A vertex query word gives one vertex word; a brick query word gives 36
// vertex words, the 12 triangles of the brick's box, the last one marked.
// Query words outside the grid give a single word with bad_cell set. The
// output channel carries one word per cycle while vertex.ready is high; the
// next query is taken in the cycle the last word of the current one leaves
// the expander, and queries flow through the expander, a multiply stage and
// the output register. Every configuration write restarts the geometry unit,
// whose three bit-serial dividers and stride multiply hold off queries while
// they run.
// ----------------------------------------------------------------------------
module brick_box_mesh_generator
(
    input  logic                           clk,
    input  logic                           rst_n,
    bbmg_query_if.sink                     query,
    bbmg_vertex_if.source                  vertex,
    input  logic                           cfg_we,
    input  logic [bbmg_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [bbmg_pkg::DIM_W-1:0]     cfg_data
);
    import bbmg_pkg::*;

    geom_t geo;

    // expander stage
    logic              seq_valid_reg;
    logic              seq_act_reg;
    logic              seq_bad_reg;
    logic [CELL_W-1:0] seq_x_reg;
    logic [CELL_W-1:0] seq_y_reg;
    logic [CELL_W-1:0] seq_z_reg;
    logic [K_W-1:0]    seq_k_reg;

    // multiply stage
    logic              s1_valid_reg;
    logic              s1_bad_reg;
    logic              s1_last_reg;
    logic [CRD_W-1:0]  s1_x_reg;
    logic [IDX_W-1:0]  s1_pz_reg;
    logic [IDX_W-1:0]  s1_py_reg;
    logic [DIM_W-1:0]  s1_cx_reg;
    logic [DIM_W-1:0]  s1_cy_reg;
    logic [DIM_W-1:0]  s1_cz_reg;
    logic              s1_ex_reg;
    logic              s1_ey_reg;
    logic              s1_ez_reg;

    // output stage
    logic              s2_valid_reg;
    logic [IDX_W-1:0]  s2_index_reg;
    logic [DIM_W-1:0]  s2_cx_reg;
    logic [DIM_W-1:0]  s2_cy_reg;
    logic [DIM_W-1:0]  s2_cz_reg;
    logic              s2_bad_reg;
    logic              s2_last_reg;

    logic              accept;
    logic              bad_in;
    logic              out_ready;
    logic              s1_ready;
    logic              seq_fire;
    logic              seq_last;
    logic [2:0]        code;
    logic [CRD_W-1:0]  ex_x;
    logic [CRD_W-1:0]  ex_y;
    logic [CRD_W-1:0]  ex_z;

    logic [CRD_W+STRZ_W-1:0] pz_full;
    logic [CRD_W+DIM_W-1:0]  py_full;
    logic [CRD_W+DIM_W-1:0]  cx_full;
    logic [CRD_W+DIM_W-1:0]  cy_full;
    logic [CRD_W+DIM_W-1:0]  cz_full;
    logic [IDX_W-1:0]        index_sum;

    bbmg_geom u_geom
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geo       (geo)
    );

    // stage handshake
    assign out_ready = !s2_valid_reg || vertex.ready;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign seq_last  = seq_bad_reg || (seq_act_reg == ACT_VERTEX) || (seq_k_reg == K_LAST);
    assign seq_fire  = seq_valid_reg && s1_ready;

    assign query.ready = !geo.busy && (!seq_valid_reg || (s1_ready && seq_last));
    assign accept      = query.valid && query.ready;

    // grid range check of the incoming word
    always_comb
    begin
        if (query.action == ACT_BRICK)
            bad_in = (query.cell_x >= geo.cnt_x) || (query.cell_y >= geo.cnt_y)
                     || (query.cell_z >= geo.cnt_z);
        else
            bad_in = (query.cell_x > geo.cnt_x) || (query.cell_y > geo.cnt_y)
                     || (query.cell_z > geo.cnt_z);
    end

    // expander control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_valid_reg <= 1'b0;
            seq_k_reg     <= '0;
        end
        else if (accept)
        begin
            seq_valid_reg <= 1'b1;
            seq_k_reg     <= '0;
        end
        else if (seq_fire)
        begin
            if (seq_last)
                seq_valid_reg <= 1'b0;
            else
                seq_k_reg <= seq_k_reg + K_W'(1);
        end
    end

    // expander payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            seq_act_reg <= query.action;
            seq_bad_reg <= bad_in;
            seq_x_reg   <= query.cell_x;
            seq_y_reg   <= query.cell_y;
            seq_z_reg   <= query.cell_z;
        end
    end

    // corner of the current triangle vertex
    assign code = (seq_act_reg == ACT_BRICK) ? CORNER_CODE[seq_k_reg] : 3'd0;
    assign ex_x = {1'b0, seq_x_reg} + CRD_W'(code[0]);
    assign ex_y = {1'b0, seq_y_reg} + CRD_W'(code[1]);
    assign ex_z = {1'b0, seq_z_reg} + CRD_W'(code[2]);

    // index terms and coordinates
    assign pz_full = {{STRZ_W{1'b0}}, ex_z} * {{CRD_W{1'b0}}, geo.stride_z};
    assign py_full = {{DIM_W{1'b0}}, ex_y} * {{CRD_W{1'b0}}, geo.stride_y};
    assign cx_full = {{DIM_W{1'b0}}, ex_x} * {{CRD_W{1'b0}}, geo.brick_len};
    assign cy_full = {{DIM_W{1'b0}}, ex_y} * {{CRD_W{1'b0}}, geo.brick_len};
    assign cz_full = {{DIM_W{1'b0}}, ex_z} * {{CRD_W{1'b0}}, geo.brick_len};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= seq_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (seq_fire)
        begin
            s1_bad_reg  <= seq_bad_reg;
            s1_last_reg <= seq_last;
            s1_x_reg    <= ex_x;
            s1_pz_reg   <= pz_full[IDX_W-1:0];
            s1_py_reg   <= IDX_W'(py_full);
            s1_cx_reg   <= cx_full[DIM_W-1:0];
            s1_cy_reg   <= cy_full[DIM_W-1:0];
            s1_cz_reg   <= cz_full[DIM_W-1:0];
            s1_ex_reg   <= (ex_x == {1'b0, geo.cnt_x});
            s1_ey_reg   <= (ex_y == {1'b0, geo.cnt_y});
            s1_ez_reg   <= (ex_z == {1'b0, geo.cnt_z});
        end
    end

    // sum of index terms, last grid line clamps to the volume
    assign index_sum = s1_pz_reg + s1_py_reg + IDX_W'(s1_x_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (out_ready)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && out_ready)
        begin
            s2_bad_reg  <= s1_bad_reg;
            s2_last_reg <= s1_last_reg;
            if (s1_bad_reg)
            begin
                s2_index_reg <= '0;
                s2_cx_reg    <= '0;
                s2_cy_reg    <= '0;
                s2_cz_reg    <= '0;
            end
            else
            begin
                s2_index_reg <= index_sum;
                s2_cx_reg    <= s1_ex_reg ? geo.dim_x : s1_cx_reg;
                s2_cy_reg    <= s1_ey_reg ? geo.dim_y : s1_cy_reg;
                s2_cz_reg    <= s1_ez_reg ? geo.dim_z : s1_cz_reg;
            end
        end
    end

    // output word
    assign vertex.valid        = s2_valid_reg;
    assign vertex.vertex_index = s2_index_reg;
    assign vertex.coord_x      = s2_cx_reg;
    assign vertex.coord_y      = s2_cy_reg;
    assign vertex.coord_z      = s2_cz_reg;
    assign vertex.bad_cell     = s2_bad_reg;
    assign vertex.last         = s2_last_reg;

    // no query taken while the geometry is being recomputed
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !geo.busy)
        else $error("query accepted during geometry update");

    // triangle counter stays inside the corner table
    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        seq_valid_reg |-> (seq_k_reg <= K_LAST))
        else $error("corner counter out of range");

    // a flagged word is the only word of its query and carries zeros
    a_bad_word: assert property (@(posedge clk) disable iff (!rst_n)
        (vertex.valid && vertex.bad_cell) |->
            (vertex.last && (vertex.vertex_index == '0) && (vertex.coord_x == '0)))
        else $error("bad cell word malformed");

    // a brick query walks its corners one step per emitted word
    a_k_step: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_fire && !seq_last && !accept) |=> (seq_k_reg == $past(seq_k_reg) + K_W'(1)))
        else $error("corner counter skipped");

endmodule
